// ===== rtl/core/idle_gap_frame_receiver_macros.svh =====
// Assertion macros used by the idle-gap frame receiver deframer.
`ifndef IDLE_GAP_FRAME_RECEIVER_MACROS_SVH
`define IDLE_GAP_FRAME_RECEIVER_MACROS_SVH

// Checks in the same cycle that the consequent holds whenever the antecedent holds.
`define IGFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks in the following cycle that the consequent holds after the antecedent.
`define IGFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/igfr_pkg.sv =====
// Package with the item types and fixed constants of the idle-gap frame receiver.
`timescale 1ns / 1ps

package igfr_pkg;

   localparam int IDX_W  = 7;
   localparam int BYTE_W = 8;
   localparam int HEADER_BYTES = 2;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   localparam logic [BYTE_W-1:0] IDLE_MAX = 8'hFF;
   localparam logic [BYTE_W-1:0] GAP_THRESHOLD_RESET = 8'd20;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_GAP_THRESHOLD = 1'b0;

   typedef struct packed {
      logic              operation;
      logic [BYTE_W-1:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]  write_index;
      logic [BYTE_W-1:0] write_data;
      logic              frame_done;
   } rsp_item_type;

endpackage

// ===== rtl/core/igfr_in_stage.sv =====
// Input register stage that holds one item until the deframer takes it.
`timescale 1ns / 1ps

module igfr_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  igfr_pkg::req_item_type req_item,
   input  logic                  advance,
   output logic                  item_valid,
   output igfr_pkg::req_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   igfr_pkg::req_item_type item_ff;
   logic                   accept;

   assign req_stall  = valid_ff && !advance;
   assign accept     = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== rtl/core/igfr_deframer.sv =====
// Deframing state machine with idle counter and the result register.
`timescale 1ns / 1ps
`include "idle_gap_frame_receiver_macros.svh"

module igfr_deframer #(
   parameter int MSG_SIZE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  igfr_pkg::req_item_type item,
   output logic                   advance,
   input  logic [igfr_pkg::BYTE_W-1:0] gap_threshold,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output igfr_pkg::rsp_item_type rsp_item
);

   localparam int LEN_W = $clog2(MSG_SIZE);
   localparam int POS_W = $clog2(MSG_SIZE + igfr_pkg::HEADER_BYTES);
   localparam logic [igfr_pkg::BYTE_W:0] MSG_LIM = (igfr_pkg::BYTE_W + 1)'(MSG_SIZE);
   localparam logic [POS_W-1:0] POS_HEADER = POS_W'(igfr_pkg::HEADER_BYTES);

   typedef enum logic [1:0] {
      ST_STANDBY,
      ST_OVERFLOW,
      ST_WAIT_LEN,
      ST_ACTIVE
   } status_type;

   status_type                   status_ff, status_in;
   logic [igfr_pkg::BYTE_W-1:0]  idle_ticks_ff, idle_ticks_in;
   logic [LEN_W-1:0]             frame_length_ff, frame_length_in;
   logic [POS_W-1:0]             byte_position_ff, byte_position_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   igfr_pkg::rsp_item_type       rsp_item_ff, rsp_item_in;
   logic [POS_W-1:0]             frame_end;
   logic [POS_W-1:0]             next_position;
   logic                         last_byte;

   assign advance       = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_item_ff;
   assign frame_end     = POS_W'(frame_length_ff) + POS_HEADER;
   assign next_position = byte_position_ff + POS_W'(1);
   assign last_byte     = (next_position == frame_end);

   always_comb begin
      status_in        = status_ff;
      idle_ticks_in    = idle_ticks_ff;
      frame_length_in  = frame_length_ff;
      byte_position_in = byte_position_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_item_in      = rsp_item_ff;
      if (advance) begin
         if (item.operation == igfr_pkg::OP_TICK) begin
            if (idle_ticks_ff != igfr_pkg::IDLE_MAX) begin
               idle_ticks_in = idle_ticks_ff + 8'd1;
            end
         end else begin
            idle_ticks_in = '0;
            if (idle_ticks_ff > gap_threshold) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.write_index  = '0;
               rsp_item_in.write_data   = item.rx_byte;
               rsp_item_in.frame_done   = 1'b0;
               status_in                = ST_WAIT_LEN;
            end else begin
               unique case (status_ff)
                  ST_WAIT_LEN: begin
                     if ({1'b0, item.rx_byte} < MSG_LIM) begin
                        frame_length_in         = item.rx_byte[LEN_W-1:0];
                        rsp_valid_in            = 1'b1;
                        rsp_item_in.write_index = igfr_pkg::IDX_W'(1);
                        rsp_item_in.write_data  = item.rx_byte;
                        rsp_item_in.frame_done  = 1'b0;
                        byte_position_in        = POS_HEADER;
                        status_in               = ST_ACTIVE;
                     end else begin
                        status_in = ST_OVERFLOW;
                     end
                  end
                  ST_ACTIVE: begin
                     if (byte_position_ff < frame_end) begin
                        rsp_valid_in            = 1'b1;
                        rsp_item_in.write_index = igfr_pkg::IDX_W'(byte_position_ff);
                        rsp_item_in.write_data  = item.rx_byte;
                        rsp_item_in.frame_done  = last_byte;
                        byte_position_in        = next_position;
                        if (last_byte) begin
                           status_in = ST_STANDBY;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff        <= ST_STANDBY;
         idle_ticks_ff    <= '0;
         frame_length_ff  <= '0;
         byte_position_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         status_ff        <= status_in;
         idle_ticks_ff    <= idle_ticks_in;
         frame_length_ff  <= frame_length_in;
         byte_position_ff <= byte_position_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   `IGFR_ASSERT_NEXT(a_done_ends_frame, clock, reset,
      advance && rsp_valid_in && rsp_item_in.frame_done,
      status_ff == ST_STANDBY, "Frame completed but receiver did not return to standby.")

   `IGFR_ASSERT_NEXT(a_byte_clears_idle, clock, reset,
      advance && item.operation == igfr_pkg::OP_BYTE,
      idle_ticks_ff == '0, "Idle counter not cleared by a received byte.")

   `IGFR_ASSERT_NEXT(a_idle_saturates, clock, reset,
      advance && item.operation == igfr_pkg::OP_TICK && idle_ticks_ff == igfr_pkg::IDLE_MAX,
      idle_ticks_ff == igfr_pkg::IDLE_MAX, "Idle counter wrapped past its maximum.")

   `IGFR_ASSERT_SAME(a_position_in_frame, clock, reset,
      status_ff == ST_ACTIVE,
      byte_position_ff <= frame_end, "Write position ran beyond the end of the frame.")

   `IGFR_ASSERT_NEXT(a_tick_gives_no_item, clock, reset,
      advance && item.operation == igfr_pkg::OP_TICK && !(rsp_valid_ff && rsp_stall),
      !rsp_valid_ff, "A timer tick produced a result item.")

endmodule

// ===== rtl/core/idle_gap_frame_receiver.sv =====
// Top level of the idle-gap frame receiver with its configuration registers.
//
// Channel   Direction  Handshake               Carries
// req       in         req_valid / req_stall   tick or received byte
// rsp       out        rsp_valid / rsp_stall   buffer write with frame done flag
// csr       in/out     psel, penable, pready   gap threshold register
//
// Each item is registered in the input register and is then resolved into the result
// register, so one item is taken per cycle when rsp_stall stays low.
// A stalled result holds the deframer, which in turn holds the input register.
// Reset is synchronous and sets the threshold to 20 and the receiver to standby.
`timescale 1ns / 1ps

module idle_gap_frame_receiver #(
   parameter int MSG_SIZE = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  igfr_pkg::req_item_type             req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output igfr_pkg::rsp_item_type             rsp_item,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [igfr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [igfr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [igfr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   logic [igfr_pkg::BYTE_W-1:0] gap_threshold_ff, gap_threshold_in;
   logic                        item_valid;
   igfr_pkg::req_item_type      item;
   logic                        advance;
   logic                        reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[igfr_pkg::CSR_ADDR_W-1:2] == igfr_pkg::REG_GAP_THRESHOLD);
   assign prdata  = reg_hit ? igfr_pkg::CSR_DATA_W'(gap_threshold_ff) : '0;

   always_comb begin
      gap_threshold_in = gap_threshold_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         gap_threshold_in = pwdata[igfr_pkg::BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_threshold_ff <= igfr_pkg::GAP_THRESHOLD_RESET;
      end else begin
         gap_threshold_ff <= gap_threshold_in;
      end
   end

   igfr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   igfr_deframer #(
      .MSG_SIZE (MSG_SIZE)
   ) u_deframer (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .advance       (advance),
      .gap_threshold (gap_threshold_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item)
   );

endmodule

// ===== sim/idle_gap_frame_receiver_checker.sv =====
// Checker that predicts the buffer writes of the idle-gap frame receiver and compares them.
`timescale 1ns / 1ps

module idle_gap_frame_receiver_checker #(
   parameter int MSG_SIZE = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  igfr_pkg::req_item_type             req_item,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  igfr_pkg::rsp_item_type             rsp_item,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic                               pready,
   input  logic [igfr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [igfr_pkg::CSR_DATA_W-1:0]    pwdata,
   output int                                 fail_count,
   output int                                 pending_writes
);

   typedef enum logic [1:0] {
      RX_STANDBY,
      RX_OVERFLOW,
      RX_WAIT_LEN,
      RX_ACTIVE
   } rx_state_type;

   logic [igfr_pkg::BYTE_W-1:0] threshold;
   logic [igfr_pkg::BYTE_W-1:0] idle_count;
   rx_state_type                rx_state;
   logic [igfr_pkg::BYTE_W-1:0] payload_length;
   logic [igfr_pkg::BYTE_W-1:0] next_index;
   igfr_pkg::rsp_item_type      expected_writes[$];

   function automatic igfr_pkg::rsp_item_type buffer_write(
         input int unsigned index,
         input logic [igfr_pkg::BYTE_W-1:0] data,
         input logic done);
      igfr_pkg::rsp_item_type w;
      w.write_index = index[igfr_pkg::IDX_W-1:0];
      w.write_data  = data;
      w.frame_done  = done;
      return w;
   endfunction

   task automatic deframe_step(input igfr_pkg::req_item_type item);
      int unsigned frame_end;
      if (item.operation == igfr_pkg::OP_TICK) begin
         if (idle_count != igfr_pkg::IDLE_MAX) idle_count++;
      end else begin
         if (idle_count > threshold) begin
            expected_writes.push_back(buffer_write(0, item.rx_byte, 1'b0));
            rx_state = RX_WAIT_LEN;
         end else if (rx_state == RX_WAIT_LEN) begin
            if (item.rx_byte < MSG_SIZE) begin
               payload_length = item.rx_byte;
               expected_writes.push_back(buffer_write(1, item.rx_byte, 1'b0));
               next_index = igfr_pkg::BYTE_W'(igfr_pkg::HEADER_BYTES);
               rx_state = RX_ACTIVE;
            end else begin
               rx_state = RX_OVERFLOW;
            end
         end else if (rx_state == RX_ACTIVE) begin
            frame_end = payload_length + igfr_pkg::HEADER_BYTES;
            // A zero length leaves the position at the end, so nothing more is written.
            if (next_index < frame_end) begin
               expected_writes.push_back(buffer_write(32'(next_index), item.rx_byte,
                                                      next_index + 1 == frame_end));
               if (next_index + 1 == frame_end) rx_state = RX_STANDBY;
               next_index++;
            end
         end
         idle_count = '0;
      end
   endtask

   task automatic note_failure(input string what, input igfr_pkg::rsp_item_type want);
      fail_count++;
      if (fail_count <= 10) begin
         $write("%0t: %s: expected index %0d data %02h done %0b, ", $time, what,
                want.write_index, want.write_data, want.frame_done);
         $display("got index %0d data %02h done %0b",
                  rsp_item.write_index, rsp_item.write_data, rsp_item.frame_done);
      end
   endtask

   always @(posedge clock) begin
      igfr_pkg::rsp_item_type oldest;
      if (reset) begin
         threshold = igfr_pkg::GAP_THRESHOLD_RESET;
         idle_count = '0;
         rx_state = RX_STANDBY;
         payload_length = '0;
         next_index = '0;
         expected_writes.delete();
      end else begin
         if (psel && penable && pwrite && pready &&
             paddr == {igfr_pkg::REG_GAP_THRESHOLD, 2'b00})
            threshold = pwdata[igfr_pkg::BYTE_W-1:0];
         if (req_valid && !req_stall) deframe_step(req_item);
         if (rsp_valid && !rsp_stall) begin
            if (expected_writes.size() == 0) begin
               note_failure("write with nothing expected", '0);
            end else begin
               oldest = expected_writes.pop_front();
               if (rsp_item.write_index !== oldest.write_index ||
                   rsp_item.write_data !== oldest.write_data ||
                   rsp_item.frame_done !== oldest.frame_done)
                  note_failure("write mismatch", oldest);
            end
         end
      end
      pending_writes = expected_writes.size();
   end

endmodule

// ===== sim/idle_gap_frame_receiver_test.sv =====
// Testbench top that drives ticks, bytes and threshold writes into the idle-gap frame receiver.
`timescale 1ns / 1ps

module idle_gap_frame_receiver_test;

   localparam int MSG_SIZE      = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   igfr_pkg::req_item_type          req_item = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   igfr_pkg::rsp_item_type          rsp_item;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [igfr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [igfr_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [igfr_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   int fail_count;
   int pending_writes;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int gap_setting = int'(igfr_pkg::GAP_THRESHOLD_RESET);
   int items_sent = 0;
   int cycle_count = 0;

   idle_gap_frame_receiver #(.MSG_SIZE(MSG_SIZE)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   idle_gap_frame_receiver_checker #(.MSG_SIZE(MSG_SIZE)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .fail_count     (fail_count),
      .pending_writes (pending_writes)
   );

   always #5 clock = ~clock;

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic op, input logic [igfr_pkg::BYTE_W-1:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item.operation <= op;
      req_item.rx_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(igfr_pkg::OP_TICK, igfr_pkg::BYTE_W'($urandom_range(255)));
   endtask

   task automatic drain_writes();
      req_valid <= 1'b0;
      while (pending_writes != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_phase(input int threshold, input int idle_pct, input int stall_pct);
      drain_writes();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {igfr_pkg::REG_GAP_THRESHOLD, 2'b00};
      pwdata <= ($urandom() & 32'hFFFF_FF00) | 32'(threshold);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      gap_setting = threshold;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // Mostly well-formed frames with random content, some broken by short gaps,
   // truncation, surplus bytes or oversized lengths, and some plain noise.
   task automatic send_frame_attempt();
      int unsigned pick;
      int unsigned length;
      int unsigned body;
      pick = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 6))
            send_item(1'($urandom_range(1)), igfr_pkg::BYTE_W'($urandom_range(255)));
         return;
      end
      pick = $urandom_range(99);
      if (pick < 80) send_ticks(gap_setting + 1 + $urandom_range(3));
      else if (pick < 90) send_ticks(gap_setting);
      else send_ticks($urandom_range(gap_setting));
      send_item(igfr_pkg::OP_BYTE, igfr_pkg::BYTE_W'($urandom_range(255)));
      pick = $urandom_range(99);
      if (pick < 75) length = $urandom_range(12);
      else if (pick < 83) length = $urandom_range(13, MSG_SIZE - 1);
      else if (pick < 88) length = MSG_SIZE - 1;
      else length = $urandom_range(MSG_SIZE, 255);
      send_item(igfr_pkg::OP_BYTE, igfr_pkg::BYTE_W'(length));
      body = length;
      pick = $urandom_range(99);
      if (body > 0 && pick < 12) body = $urandom_range(body - 1);
      else if (pick > 89) body = body + $urandom_range(1, 3);
      if (body > MSG_SIZE + 3) body = $urandom_range(3);
      for (int i = 0; i < body; i++) begin
         if (gap_setting > 0 && $urandom_range(99) < 5)
            send_ticks($urandom_range(1, gap_setting < 4 ? gap_setting : 4));
         send_item(igfr_pkg::OP_BYTE, igfr_pkg::BYTE_W'($urandom_range(255)));
      end
   endtask

   initial begin
      int threshold;
      int budget;
      int phase_end;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With a threshold of zero a single tick makes a gap.
      set_phase(0, 0, 0);
      send_item(igfr_pkg::OP_BYTE, 8'hFF);
      send_item(igfr_pkg::OP_TICK, 8'h00);
      send_item(igfr_pkg::OP_BYTE, 8'h00);
      send_item(igfr_pkg::OP_BYTE, 8'h00);
      send_item(igfr_pkg::OP_BYTE, 8'hAA);
      send_item(igfr_pkg::OP_TICK, 8'hFF);
      send_item(igfr_pkg::OP_BYTE, 8'h80);
      send_item(igfr_pkg::OP_BYTE, 8'h01);
      send_item(igfr_pkg::OP_BYTE, 8'hFF);
      send_item(igfr_pkg::OP_TICK, 8'h5A);
      send_item(igfr_pkg::OP_BYTE, 8'h7F);
      send_item(igfr_pkg::OP_BYTE, igfr_pkg::BYTE_W'(MSG_SIZE));
      send_item(igfr_pkg::OP_BYTE, 8'h55);
      send_item(igfr_pkg::OP_TICK, 8'hA5);
      send_item(igfr_pkg::OP_BYTE, 8'h01);
      send_item(igfr_pkg::OP_BYTE, 8'hFF);
      send_item(igfr_pkg::OP_TICK, 8'h00);
      send_item(igfr_pkg::OP_BYTE, 8'h02);
      send_item(igfr_pkg::OP_BYTE, 8'h03);
      send_item(igfr_pkg::OP_BYTE, 8'h11);
      send_item(igfr_pkg::OP_TICK, 8'h00);
      send_item(igfr_pkg::OP_BYTE, 8'h33);
      send_item(igfr_pkg::OP_BYTE, igfr_pkg::BYTE_W'(MSG_SIZE - 1));
      send_item(igfr_pkg::OP_BYTE, 8'h12);
      send_item(igfr_pkg::OP_BYTE, 8'h34);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: threshold = 0;
            1: threshold = 3;
            2: threshold = 1;
            4: threshold = 254;
            5: threshold = 255;
            6: threshold = 2;
            default: threshold = $urandom_range(4, 30);
         endcase
         case (p % 4)
            0: set_phase(threshold, 0, 0);
            1: set_phase(threshold, 70, 0);
            2: set_phase(threshold, 0, 70);
            default: set_phase(threshold, 24, 24);
         endcase
         if (p == 4 || p == 5) budget = 1;
         else budget = 170;
         phase_end = items_sent + budget;
         while (items_sent < phase_end) send_frame_attempt();
      end

      drain_writes();
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
